// File: hw/rtl/rcexpo_pkg.sv
// ---------------------------------------------------------------------------
// rcexpo_pkg
// Shared types, constants and the curve-point table of the stick shaping
// and heading hold block.
// ---------------------------------------------------------------------------
`default_nettype none

package rcexpo_pkg;

  // Command limits and angle constants
  localparam int unsigned CMD_LIMIT = 500;
  localparam int unsigned THR_TOP   = 2000;
  localparam int unsigned YAW_DEAD  = 70;
  localparam int unsigned CURVE_DIV = 2500;
  localparam int unsigned SEG_LEN   = 100;
  localparam int unsigned HALF_TURN = 180;
  localparam int unsigned FULL_TURN = 360;
  localparam int          YAW_MAX   = 4095;
  localparam int          YAW_MIN   = -4096;

  // Reciprocals for the constant divides: q0 = (x * RECIP) >> SHIFT gives
  // floor(x / div) or one less, fixed by a single remainder compare.
  localparam logic [23:0] RECIP_2500 = 24'd13743895;  // floor(2^35 / 2500)
  localparam int unsigned SHIFT_2500 = 35;
  localparam logic [19:0] RECIP_100  = 20'd671088;    // floor(2^26 / 100)
  localparam int unsigned SHIFT_100  = 26;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_EXPO         = 3'd0,
    CFG_RATE         = 3'd1,
    CFG_STICK_MID    = 3'd2,
    CFG_MIN_CHECK    = 3'd3,
    CFG_HEADING_GAIN = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [6:0]  expo;
    logic [7:0]  rate;
    logic [10:0] stick_mid;
    logic [10:0] min_check;
    logic [7:0]  heading_gain;
  } cfg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EK,
    ST_SCALE,
    ST_RECIP,
    ST_FIX,
    ST_IMUL,
    ST_IRECIP,
    ST_IFIX,
    ST_YAW_MUL,
    ST_YAW_FIN,
    ST_DONE
  } ctrl_state_e;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SETUP,
    OP_EK,
    OP_SCALE,
    OP_RECIP,
    OP_FIX,
    OP_IMUL,
    OP_IRECIP,
    OP_IFIX,
    OP_YAW_MUL,
    OP_YAW_FIN,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   chan;  // 0: roll, 1: pitch
    logic   pt;    // 0: lower curve point, 1: upper curve point
  } dp_cmd_t;

  // Curve point i uses (i*i - 25) as the expo weight
  function automatic logic signed [5:0] curve_k(input logic [2:0] idx);
    logic signed [5:0] k;
    begin
      case (idx)
        3'd0:    k = -6'sd25;
        3'd1:    k = -6'sd24;
        3'd2:    k = -6'sd21;
        3'd3:    k = -6'sd16;
        3'd4:    k = -6'sd9;
        3'd5:    k = 6'sd0;
        3'd6:    k = 6'sd11;
        default: k = 6'sd0;
      endcase
      return k;
    end
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rcexpo_cfg.sv
// ---------------------------------------------------------------------------
// rcexpo_cfg
// Configuration registers, written through a plain write port.
// ---------------------------------------------------------------------------
`default_nettype none

module rcexpo_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [10:0]        cfg_data_i,
  output rcexpo_pkg::cfg_t   cfg_o
);

  rcexpo_pkg::cfg_t cfg_q;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expo         <= 7'd65;
      cfg_q.rate         <= 8'd90;
      cfg_q.stick_mid    <= 11'd1500;
      cfg_q.min_check    <= 11'd1100;
      cfg_q.heading_gain <= 8'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rcexpo_pkg::CFG_EXPO:         cfg_q.expo         <= cfg_data_i[6:0];
        rcexpo_pkg::CFG_RATE:         cfg_q.rate         <= cfg_data_i[7:0];
        rcexpo_pkg::CFG_STICK_MID:    cfg_q.stick_mid    <= cfg_data_i;
        rcexpo_pkg::CFG_MIN_CHECK:    cfg_q.min_check    <= cfg_data_i;
        rcexpo_pkg::CFG_HEADING_GAIN: cfg_q.heading_gain <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/rcexpo_ctrl.sv
// ---------------------------------------------------------------------------
// rcexpo_ctrl
// Sequencer: walks the datapath through curve points, interpolation and
// heading hold for each transaction, and owns both handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

module rcexpo_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rcexpo_pkg::dp_cmd_t cmd_o
);

  rcexpo_pkg::ctrl_state_e state_q, state_d;
  logic chan_q, chan_d;
  logic pt_q, pt_d;
  logic out_valid_q, out_valid_d;
  logic out_slot_free;

  assign out_slot_free = !out_valid_q || out_ready_i;

  // Next state and loop counters
  always_comb begin
    state_d = state_q;
    chan_d  = chan_q;
    pt_d    = pt_q;
    unique case (state_q)
      rcexpo_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = rcexpo_pkg::ST_SETUP;
          chan_d  = 1'b0;
        end
      end
      rcexpo_pkg::ST_SETUP: begin
        state_d = rcexpo_pkg::ST_EK;
        pt_d    = 1'b0;
      end
      rcexpo_pkg::ST_EK:     state_d = rcexpo_pkg::ST_SCALE;
      rcexpo_pkg::ST_SCALE:  state_d = rcexpo_pkg::ST_RECIP;
      rcexpo_pkg::ST_RECIP:  state_d = rcexpo_pkg::ST_FIX;
      rcexpo_pkg::ST_FIX: begin
        if (!pt_q) begin
          state_d = rcexpo_pkg::ST_EK;
          pt_d    = 1'b1;
        end else begin
          state_d = rcexpo_pkg::ST_IMUL;
        end
      end
      rcexpo_pkg::ST_IMUL:   state_d = rcexpo_pkg::ST_IRECIP;
      rcexpo_pkg::ST_IRECIP: state_d = rcexpo_pkg::ST_IFIX;
      rcexpo_pkg::ST_IFIX: begin
        if (!chan_q) begin
          state_d = rcexpo_pkg::ST_SETUP;
          chan_d  = 1'b1;
        end else begin
          state_d = rcexpo_pkg::ST_YAW_MUL;
        end
      end
      rcexpo_pkg::ST_YAW_MUL: state_d = rcexpo_pkg::ST_YAW_FIN;
      rcexpo_pkg::ST_YAW_FIN: state_d = rcexpo_pkg::ST_DONE;
      rcexpo_pkg::ST_DONE: begin
        if (out_slot_free) begin
          state_d = rcexpo_pkg::ST_IDLE;
        end
      end
      default: state_d = rcexpo_pkg::ST_IDLE;
    endcase
  end

  // Output register valid: set on load, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (state_q == rcexpo_pkg::ST_DONE && out_slot_free) begin
      out_valid_d = 1'b1;
    end
  end

  // Commands to the datapath
  always_comb begin
    cmd_o.chan = chan_q;
    cmd_o.pt   = pt_q;
    cmd_o.op   = rcexpo_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      rcexpo_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = rcexpo_pkg::OP_CAPTURE;
        end
      end
      rcexpo_pkg::ST_SETUP:   cmd_o.op = rcexpo_pkg::OP_SETUP;
      rcexpo_pkg::ST_EK:      cmd_o.op = rcexpo_pkg::OP_EK;
      rcexpo_pkg::ST_SCALE:   cmd_o.op = rcexpo_pkg::OP_SCALE;
      rcexpo_pkg::ST_RECIP:   cmd_o.op = rcexpo_pkg::OP_RECIP;
      rcexpo_pkg::ST_FIX:     cmd_o.op = rcexpo_pkg::OP_FIX;
      rcexpo_pkg::ST_IMUL:    cmd_o.op = rcexpo_pkg::OP_IMUL;
      rcexpo_pkg::ST_IRECIP:  cmd_o.op = rcexpo_pkg::OP_IRECIP;
      rcexpo_pkg::ST_IFIX:    cmd_o.op = rcexpo_pkg::OP_IFIX;
      rcexpo_pkg::ST_YAW_MUL: cmd_o.op = rcexpo_pkg::OP_YAW_MUL;
      rcexpo_pkg::ST_YAW_FIN: cmd_o.op = rcexpo_pkg::OP_YAW_FIN;
      rcexpo_pkg::ST_DONE: begin
        if (out_slot_free) begin
          cmd_o.op = rcexpo_pkg::OP_OUT;
        end
      end
      default: cmd_o.op = rcexpo_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rcexpo_pkg::ST_IDLE;
      chan_q      <= 1'b0;
      pt_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chan_q      <= chan_d;
      pt_q        <= pt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: hw/rtl/rcexpo_dp.sv
// ---------------------------------------------------------------------------
// rcexpo_dp
// Datapath: one shared signed multiplier serves the curve points, the
// reciprocal divides, the interpolation and the heading hold gain.
// ---------------------------------------------------------------------------
`default_nettype none

module rcexpo_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rcexpo_pkg::cfg_t    cfg_i,
  input  rcexpo_pkg::dp_cmd_t cmd_i,
  input  logic [11:0]         roll_raw_i,
  input  logic [11:0]         pitch_raw_i,
  input  logic [11:0]         yaw_raw_i,
  input  logic [11:0]         throttle_raw_i,
  input  logic signed [8:0]   heading_i,
  input  logic                alt_hold_i,
  output logic signed [9:0]   roll_cmd_o,
  output logic signed [9:0]   pitch_cmd_o,
  output logic signed [12:0]  yaw_cmd_o,
  output logic [10:0]         throttle_cmd_o
);

  localparam logic signed [12:0] CURVE_BASE = 13'(rcexpo_pkg::CURVE_DIV);
  localparam logic [8:0]         D_LIMIT    = 9'(rcexpo_pkg::CMD_LIMIT);
  localparam logic [24:0]        DIV_2500   = 25'(rcexpo_pkg::CURVE_DIV);
  localparam logic [24:0]        DIV_100    = 25'(rcexpo_pkg::SEG_LEN);
  localparam logic signed [14:0] V_LIM      = 15'(rcexpo_pkg::CMD_LIMIT);
  localparam logic signed [12:0] Y_LIM      = 13'(rcexpo_pkg::CMD_LIMIT);
  localparam logic signed [9:0]  Y_DEAD     = 10'(rcexpo_pkg::YAW_DEAD);
  localparam logic signed [10:0] HALF       = 11'(rcexpo_pkg::HALF_TURN);
  localparam logic signed [10:0] FULL       = 11'(rcexpo_pkg::FULL_TURN);
  localparam logic signed [18:0] YQ_MAX     = 19'(rcexpo_pkg::YAW_MAX);
  localparam logic signed [18:0] YQ_MIN     = 19'(rcexpo_pkg::YAW_MIN);
  localparam logic [11:0]        THR_MAX    = 12'(rcexpo_pkg::THR_TOP);

  // Captured frame
  logic [11:0]        roll_raw_q, pitch_raw_q, yaw_raw_q, thr_q;
  logic signed [8:0]  head_q;
  // Persistent state
  logic signed [8:0]  hold_heading_q;
  logic [10:0]        throttle_hold_q;
  // Working registers
  logic [2:0]         s_q;
  logic [6:0]         frac_q;
  logic               neg_q;
  logic signed [12:0] t_q;
  logic [10:0]        ir_q;
  logic [22:0]        x_q;
  logic               sgn_q;
  logic [12:0]        q0_q;
  logic signed [12:0] pa_q, pb_q;
  logic signed [9:0]  roll_res_q, pitch_res_q;
  logic signed [9:0]  yc_q;
  logic               hh_cond_q;
  logic signed [17:0] prod_q;
  logic signed [12:0] yaw_res_q;
  // Output register
  logic signed [9:0]  roll_cmd_q, pitch_cmd_q;
  logic signed [12:0] yaw_cmd_q;
  logic [10:0]        throttle_cmd_q;

  // Combinational signals
  logic [11:0]        raw_sel;
  logic signed [12:0] off;
  logic [11:0]        off_mag;
  logic [8:0]         d_mag;
  logic [2:0]         s_d;
  logic [8:0]         seg_base;
  logic [6:0]         frac_d;
  logic [2:0]         pt_idx;
  logic signed [5:0]  k_val;
  logic [10:0]        ir_d;
  logic signed [12:0] t_d;
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] mul_p;
  logic [49:0]        mul_mag;
  logic [12:0]        q0_d;
  logic [22:0]        rem;
  logic [22:0]        div_sel;
  logic [12:0]        q_fix;
  logic signed [13:0] q_signed;
  logic signed [13:0] diff;
  logic signed [14:0] v_sum, v_neg;
  logic signed [9:0]  v_sat;
  logic signed [12:0] yoff;
  logic signed [9:0]  yc;
  logic               hh_cond;
  logic signed [10:0] dif0, dif1, dif2;
  logic signed [18:0] ysum, yadj, yquo;
  logic signed [12:0] ysat, yaw_res_d;
  logic [11:0]        thr_lo;
  logic [10:0]        thr_clamp;

  // Stick offset, segment and fraction of the current channel
  always_comb begin
    raw_sel = cmd_i.chan ? pitch_raw_q : roll_raw_q;
    off     = $signed({1'b0, raw_sel}) - $signed({2'b00, cfg_i.stick_mid});
    off_mag = off[12] ? 12'(-off) : 12'(off);
    d_mag   = (off_mag > 12'(D_LIMIT)) ? D_LIMIT : off_mag[8:0];
    if (d_mag >= 9'd500) begin
      s_d = 3'd5; seg_base = 9'd500;
    end else if (d_mag >= 9'd400) begin
      s_d = 3'd4; seg_base = 9'd400;
    end else if (d_mag >= 9'd300) begin
      s_d = 3'd3; seg_base = 9'd300;
    end else if (d_mag >= 9'd200) begin
      s_d = 3'd2; seg_base = 9'd200;
    end else if (d_mag >= 9'd100) begin
      s_d = 3'd1; seg_base = 9'd100;
    end else begin
      s_d = 3'd0; seg_base = 9'd0;
    end
    frac_d = 7'(d_mag - seg_base);
  end

  // Curve point index, expo weight and i * rate by shift and add
  always_comb begin
    pt_idx = s_q + {2'b00, cmd_i.pt};
    k_val  = rcexpo_pkg::curve_k(pt_idx);
    ir_d   = ({3'b000, cfg_i.rate} & {11{pt_idx[0]}})
           + ({2'b00, cfg_i.rate, 1'b0} & {11{pt_idx[1]}})
           + ({1'b0, cfg_i.rate, 2'b00} & {11{pt_idx[2]}});
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      rcexpo_pkg::OP_EK: begin
        mul_a = {18'b0, cfg_i.expo};
        mul_b = {{19{k_val[5]}}, k_val};
      end
      rcexpo_pkg::OP_SCALE: begin
        mul_a = {{12{t_q[12]}}, t_q};
        mul_b = {14'b0, ir_q};
      end
      rcexpo_pkg::OP_RECIP: begin
        mul_a = {2'b00, x_q};
        mul_b = {1'b0, rcexpo_pkg::RECIP_2500};
      end
      rcexpo_pkg::OP_IRECIP: begin
        mul_a = {2'b00, x_q};
        mul_b = {5'b0, rcexpo_pkg::RECIP_100};
      end
      rcexpo_pkg::OP_FIX: begin
        mul_a = {12'b0, q0_q};
        mul_b = DIV_2500;
      end
      rcexpo_pkg::OP_IFIX: begin
        mul_a = {12'b0, q0_q};
        mul_b = DIV_100;
      end
      rcexpo_pkg::OP_IMUL: begin
        mul_a = {18'b0, frac_q};
        mul_b = {{11{diff[13]}}, diff};
      end
      rcexpo_pkg::OP_YAW_MUL: begin
        mul_a = {{14{dif2[10]}}, dif2};
        mul_b = {17'b0, cfg_i.heading_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign mul_mag = mul_p[49] ? 50'(-mul_p) : 50'(mul_p);
  assign t_d     = CURVE_BASE + $signed(mul_p[12:0]);

  // Reciprocal quotient estimate and one-step remainder correction
  always_comb begin
    q0_d     = (cmd_i.op == rcexpo_pkg::OP_IRECIP) ? mul_p[rcexpo_pkg::SHIFT_100 +: 13]
                                                    : mul_p[rcexpo_pkg::SHIFT_2500 +: 13];
    div_sel  = (cmd_i.op == rcexpo_pkg::OP_IFIX) ? DIV_100[22:0] : DIV_2500[22:0];
    rem      = x_q - mul_p[22:0];
    q_fix    = q0_q + {12'b0, (rem >= div_sel)};
    q_signed = sgn_q ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});
  end

  // Interpolation, stick sign and command limit
  always_comb begin
    diff  = $signed({pb_q[12], pb_q}) - $signed({pa_q[12], pa_q});
    v_sum = $signed({{2{pa_q[12]}}, pa_q}) + $signed({q_signed[13], q_signed});
    v_neg = neg_q ? -v_sum : v_sum;
    if (v_neg > V_LIM) begin
      v_sat = 10'(V_LIM);
    end else if (v_neg < -V_LIM) begin
      v_sat = 10'(-V_LIM);
    end else begin
      v_sat = v_neg[9:0];
    end
  end

  // Yaw offset, hold window and wrapped heading error
  always_comb begin
    yoff = $signed({2'b00, cfg_i.stick_mid}) - $signed({1'b0, yaw_raw_q});
    if (yoff > Y_LIM) begin
      yc = 10'(Y_LIM);
    end else if (yoff < -Y_LIM) begin
      yc = 10'(-Y_LIM);
    end else begin
      yc = yoff[9:0];
    end
    hh_cond = (yc > -Y_DEAD) && (yc < Y_DEAD) && (thr_q > {1'b0, cfg_i.min_check});
    dif0 = $signed({{2{head_q[8]}}, head_q}) - $signed({{2{hold_heading_q[8]}}, hold_heading_q});
    dif1 = (dif0 <= -HALF) ? dif0 + FULL : dif0;
    dif2 = (dif1 >= HALF) ? dif1 - FULL : dif1;
  end

  // Heading correction: divide by 16 toward zero, then saturate
  always_comb begin
    ysum = $signed({{5{yc_q[9]}}, yc_q, 4'b0000}) + $signed({prod_q[17], prod_q});
    yadj = ysum + (ysum[18] ? 19'sd15 : 19'sd0);
    yquo = yadj >>> 4;
    if (yquo > YQ_MAX) begin
      ysat = 13'(YQ_MAX);
    end else if (yquo < YQ_MIN) begin
      ysat = 13'(YQ_MIN);
    end else begin
      ysat = yquo[12:0];
    end
    yaw_res_d = hh_cond_q ? ysat : {{3{yc_q[9]}}, yc_q};
  end

  // Throttle clamp to min-check .. top
  always_comb begin
    thr_lo    = (throttle_raw_i < {1'b0, cfg_i.min_check}) ? {1'b0, cfg_i.min_check}
                                                           : throttle_raw_i;
    thr_clamp = (thr_lo > THR_MAX) ? THR_MAX[10:0] : thr_lo[10:0];
  end

  // Persistent state: throttle hold and hold heading
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      throttle_hold_q <= '0;
      hold_heading_q  <= '0;
    end else begin
      if (cmd_i.op == rcexpo_pkg::OP_CAPTURE && !alt_hold_i) begin
        throttle_hold_q <= thr_clamp;
      end
      if (cmd_i.op == rcexpo_pkg::OP_YAW_MUL && !hh_cond) begin
        hold_heading_q <= head_q;
      end
    end
  end

  // Working and output registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op) inside
      rcexpo_pkg::OP_CAPTURE: begin
        roll_raw_q  <= roll_raw_i;
        pitch_raw_q <= pitch_raw_i;
        yaw_raw_q   <= yaw_raw_i;
        thr_q       <= throttle_raw_i;
        head_q      <= heading_i;
      end
      rcexpo_pkg::OP_SETUP: begin
        s_q    <= s_d;
        frac_q <= frac_d;
        neg_q  <= off[12];
      end
      rcexpo_pkg::OP_EK: begin
        t_q  <= t_d;
        ir_q <= ir_d;
      end
      rcexpo_pkg::OP_SCALE, rcexpo_pkg::OP_IMUL: begin
        x_q   <= mul_mag[22:0];
        sgn_q <= mul_p[49];
      end
      rcexpo_pkg::OP_RECIP, rcexpo_pkg::OP_IRECIP: begin
        q0_q <= q0_d;
      end
      rcexpo_pkg::OP_FIX: begin
        if (cmd_i.pt) begin
          pb_q <= q_signed[12:0];
        end else begin
          pa_q <= q_signed[12:0];
        end
      end
      rcexpo_pkg::OP_IFIX: begin
        if (cmd_i.chan) begin
          pitch_res_q <= v_sat;
        end else begin
          roll_res_q <= v_sat;
        end
      end
      rcexpo_pkg::OP_YAW_MUL: begin
        yc_q      <= yc;
        hh_cond_q <= hh_cond;
        prod_q    <= mul_p[17:0];
      end
      rcexpo_pkg::OP_YAW_FIN: begin
        yaw_res_q <= yaw_res_d;
      end
      rcexpo_pkg::OP_OUT: begin
        roll_cmd_q     <= roll_res_q;
        pitch_cmd_q    <= pitch_res_q;
        yaw_cmd_q      <= yaw_res_q;
        throttle_cmd_q <= throttle_hold_q;
      end
      default: begin
      end
    endcase
  end

  assign roll_cmd_o     = roll_cmd_q;
  assign pitch_cmd_o    = pitch_cmd_q;
  assign yaw_cmd_o      = yaw_cmd_q;
  assign throttle_cmd_o = throttle_cmd_q;

endmodule

`default_nettype wire

// File: hw/rtl/rc_stick_expo_and_heading_hold.sv
// ---------------------------------------------------------------------------
// rc_stick_expo_and_heading_hold
// Stick shaping (expo/rate curve with interpolation) and heading hold for
// one RC frame per transaction.
// ---------------------------------------------------------------------------
// One input transaction gives one result transaction. Each frame is worked
// on from acceptance until its result sits in the output register, and a
// new frame is accepted in the cycle after that, not before. The pace is
// set by the
// sequencer stepping a single shared 25x25 multiplier through two curve
// points, the interpolation and three reciprocal divides per stick, then the
// heading gain. The output register frees the input side: a finished
// result may wait while the next frame is already being worked on.
// Configuration writes take effect at once and belong in idle periods.
`default_nettype none

module rc_stick_expo_and_heading_hold (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [10:0]        cfg_data_i,
  // Input frame
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [11:0]        roll_raw_i,
  input  logic [11:0]        pitch_raw_i,
  input  logic [11:0]        yaw_raw_i,
  input  logic [11:0]        throttle_raw_i,
  input  logic signed [8:0]  heading_i,
  input  logic               alt_hold_i,
  // Command result
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [9:0]  roll_cmd_o,
  output logic signed [9:0]  pitch_cmd_o,
  output logic signed [12:0] yaw_cmd_o,
  output logic [10:0]        throttle_cmd_o
);

  rcexpo_pkg::cfg_t    cfg;
  rcexpo_pkg::dp_cmd_t cmd;

  // Configuration registers
  rcexpo_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Sequencer
  rcexpo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Datapath
  rcexpo_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .roll_raw_i     (roll_raw_i),
    .pitch_raw_i    (pitch_raw_i),
    .yaw_raw_i      (yaw_raw_i),
    .throttle_raw_i (throttle_raw_i),
    .heading_i      (heading_i),
    .alt_hold_i     (alt_hold_i),
    .roll_cmd_o     (roll_cmd_o),
    .pitch_cmd_o    (pitch_cmd_o),
    .yaw_cmd_o      (yaw_cmd_o),
    .throttle_cmd_o (throttle_cmd_o)
  );

endmodule

`default_nettype wire
